[sv/kcc_pkg.sv]
package kcc_pkg;

  // defaults for the top-level parameters
  localparam int DEFAULT_MAX_CENTERS = 16;
  localparam int DEFAULT_MAX_DIMS    = 64;
  localparam int DEFAULT_COORD_BITS  = 16;

  // field widths
  localparam int OP_W    = 2;
  localparam int CI_W    = 4;
  localparam int DI_W    = 6;
  localparam int COORD_W = 16;
  localparam int DIST_W  = 38;
  localparam int TOTAL_W = 63;

  // configuration registers
  localparam int NC_W       = 5;
  localparam int ND_W       = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CENTERS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS    = CFG_IDX_W'(1);

  // stream packing
  localparam int S_TUSER_W = OP_W;
  localparam int CI_LSB    = 0;
  localparam int DI_LSB    = CI_LSB + CI_W;
  localparam int COORD_LSB = DI_LSB + DI_W;
  localparam int S_USED_W  = COORD_LSB + COORD_W;
  localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;
  localparam int M_USED_W  = DIST_W + TOTAL_W + 1;
  localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

  // opcodes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_POINT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // control token that walks down the cell chain
  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] op;
    logic [CI_W-1:0] ci;
    logic [DI_W-1:0] di;
    logic            last;   // last dimension of a point
  } tok_t;

endpackage

[sv/kcc_cell.sv]
module kcc_cell #(
  parameter int IDX        = 0,
  parameter int MAX_DIMS   = kcc_pkg::DEFAULT_MAX_DIMS,
  parameter int COORD_BITS = kcc_pkg::DEFAULT_COORD_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic [kcc_pkg::NC_W-1:0]  nc_eff,
  input  kcc_pkg::tok_t             tok_in,
  input  logic [COORD_BITS-1:0]     coord_in,
  input  logic [kcc_pkg::DIST_W-1:0] best_in,
  output kcc_pkg::tok_t             tok_out,
  output logic [COORD_BITS-1:0]     coord_out,
  output logic [kcc_pkg::DIST_W-1:0] best_out
);
  import kcc_pkg::*;

  localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int PW = 2 * (COORD_BITS + 1);
  localparam int EW = (PW > DIST_W) ? PW : DIST_W;

  // this center's coordinates, one entry per dimension
  logic [COORD_BITS-1:0] mem [MAX_DIMS];

  logic [AW-1:0]         addr;
  logic                  wr_en;
  logic [COORD_BITS-1:0] center_q;

  tok_t                  tok1;
  logic [COORD_BITS-1:0] coord1;
  logic [DIST_W-1:0]     best1;

  tok_t                  tok2;
  logic [COORD_BITS-1:0] coord2;
  logic [DIST_W-1:0]     best2;
  logic [DIST_W-1:0]     sq2;

  logic signed [COORD_BITS:0] diff;
  logic [COORD_BITS:0]        mag;
  logic [PW-1:0]              prod;
  logic [EW-1:0]              prod_w;
  logic [DIST_W-1:0]          sq_next;

  logic [DIST_W-1:0] partial;
  logic [DIST_W-1:0] partial_next;
  logic [DIST_W-1:0] acc_base;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] acc;
  logic [DIST_W-1:0] best_next;
  logic              is_pt;
  logic              active;

  assign addr  = AW'(tok_in.di);
  assign wr_en = adv && tok_in.valid && (tok_in.op == OP_LOAD) &&
                 (int'(tok_in.ci) == IDX) && (int'(tok_in.di) < MAX_DIMS);

  // stage 1: center store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= coord_in;
    end
    if (adv) begin
      center_q <= mem[addr];
      coord1   <= coord_in;
      best1    <= best_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok1 <= '0;
    end else if (adv) begin
      tok1 <= tok_in;
    end
  end

  // stage 2: squared difference, saturated to the distance width
  always_comb begin
    diff    = $signed({coord1[COORD_BITS-1], coord1}) -
              $signed({center_q[COORD_BITS-1], center_q});
    mag     = diff[COORD_BITS] ? (COORD_BITS + 1)'(-diff) : (COORD_BITS + 1)'(diff);
    prod    = PW'(mag) * PW'(mag);
    prod_w  = EW'(prod);
    sq_next = (prod_w > EW'(DIST_MAX)) ? DIST_MAX : DIST_W'(prod_w);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      coord2 <= coord1;
      best2  <= best1;
      sq2    <= sq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok2 <= '0;
    end else if (adv) begin
      tok2 <= tok1;
    end
  end

  // stage 3: accumulate and fold into the running minimum
  always_comb begin
    is_pt    = tok2.valid && (tok2.op == OP_POINT);
    active   = IDX < int'(nc_eff);
    acc_base = (tok2.di == '0) ? '0 : partial;
    sum      = {1'b0, acc_base} + {1'b0, sq2};
    acc      = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

    partial_next = partial;
    if (is_pt) begin
      if (active) begin
        partial_next = acc;
      end else if (tok2.di == '0) begin
        partial_next = '0;
      end
    end

    best_next = best2;
    if (is_pt && active && ((IDX == 0) || (acc < best2))) begin
      best_next = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial       <= '0;
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      partial <= partial_next;
      tok_out <= tok2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      coord_out <= coord2;
      best_out  <= best_next;
    end
  end

endmodule

[sv/kcc_total.sv]
module kcc_total (
  input  logic                        clk,
  input  logic                        rst,
  input  kcc_pkg::tok_t               tok_end,
  input  logic [kcc_pkg::DIST_W-1:0]  best_end,
  input  logic                        out_ready,
  output logic                        adv,
  output logic                        out_valid,
  output logic [kcc_pkg::DIST_W-1:0]  point_cost,
  output logic [kcc_pkg::TOTAL_W-1:0] run_total,
  output logic                        total_saturated
);
  import kcc_pkg::*;

  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;
  logic               sat;
  logic               sat_next;
  logic [TOTAL_W:0]   sum;
  logic               emit;

  assign adv  = !out_valid || out_ready;
  assign emit = tok_end.valid && (tok_end.op == OP_POINT) && tok_end.last;
  assign sum  = {1'b0, total} + (TOTAL_W + 1)'(best_end);

  always_comb begin
    total_next = total;
    sat_next   = sat;
    if (tok_end.valid && (tok_end.op == OP_CLEAR)) begin
      total_next = '0;
      sat_next   = 1'b0;
    end else if (emit) begin
      if (sum[TOTAL_W]) begin
        total_next = TOTAL_MAX;
        sat_next   = 1'b1;
      end else begin
        total_next = sum[TOTAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      total     <= total_next;
      sat       <= sat_next;
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      point_cost      <= best_end;
      run_total       <= total_next;
      total_saturated <= sat_next;
    end
  end

endmodule

[sv/kmeans_clustering_cost_top.sv]
// K-means clustering cost, squared Euclidean distance, fixed point.
//
// Input stream (s_*): one transaction per coordinate. s_tuser carries the
// opcode (load center coordinate, point coordinate, clear total). Centers are
// loaded one coordinate at a time; points then stream dimension 0 first.
// Output stream (m_*): one transaction after the last dimension of a point,
// with the point's smallest squared distance, the running total and the
// total's saturation flag. Loads, clears and ignored items give no output.
// Config port: cfg_we/cfg_index/cfg_data write num_centers and num_dims;
// write only while the block is idle.
// Structure: a chain of one cell per center; each cell keeps its center in
// a local memory and the partial distance for the current point, and hands
// the coordinate and the running minimum on to the next cell every cycle that the chain is not stalled.
// Throughput: one transaction per cycle while no result waits on m_tready.
// From input to output a transaction passes three register stages per cell
// and then the output register.
// Reset (rst, synchronous): total, flag and partial distances clear, both
// registers return to 1. Center memories are not cleared.
// Stall: while a result waits on m_tready the whole chain holds and
// s_tready is low, as it is during reset; otherwise s_tready is high.
module kmeans_clustering_cost_top #(
  parameter int MAX_CENTERS = kcc_pkg::DEFAULT_MAX_CENTERS,
  parameter int MAX_DIMS    = kcc_pkg::DEFAULT_MAX_DIMS,
  parameter int COORD_BITS  = kcc_pkg::DEFAULT_COORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [3:0] center_index, [9:4] dim_index, [25:10] coord, upper bits zero
  input  logic [kcc_pkg::S_TDATA_W-1:0]   s_tdata,
  // [1:0] opcode
  input  logic [kcc_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [37:0] point_cost, [100:38] run_total, [101] total_saturated, rest zero
  output logic [kcc_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                            cfg_we,
  input  logic [kcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kcc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kcc_pkg::*;

  logic [NC_W-1:0] num_centers;
  logic [ND_W-1:0] num_dims;
  logic [NC_W-1:0] nc_eff;
  logic [ND_W-1:0] nd_eff;

  logic [CI_W-1:0]    ci_f;
  logic [DI_W-1:0]    di_f;
  logic [COORD_W-1:0] coord_f;
  logic [OP_W-1:0]    op_f;
  logic               pt_ok;

  logic adv;

  tok_t                  tok_c   [MAX_CENTERS+1];
  logic [COORD_BITS-1:0] coord_c [MAX_CENTERS+1];
  logic [DIST_W-1:0]     best_c  [MAX_CENTERS+1];

  logic [DIST_W-1:0]  point_cost;
  logic [TOTAL_W-1:0] run_total;
  logic               total_saturated;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_centers <= NC_W'(1);
      num_dims    <= ND_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_CENTERS: num_centers <= cfg_data[NC_W-1:0];
        REG_NUM_DIMS:    num_dims    <= cfg_data[ND_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, values past the size clamp to it
  always_comb begin
    if (num_centers == '0) begin
      nc_eff = NC_W'(1);
    end else if (int'(num_centers) > MAX_CENTERS) begin
      nc_eff = NC_W'(MAX_CENTERS);
    end else begin
      nc_eff = num_centers;
    end
    if (num_dims == '0) begin
      nd_eff = ND_W'(1);
    end else if (int'(num_dims) > MAX_DIMS) begin
      nd_eff = ND_W'(MAX_DIMS);
    end else begin
      nd_eff = num_dims;
    end
  end

  assign ci_f    = s_tdata[CI_LSB +: CI_W];
  assign di_f    = s_tdata[DI_LSB +: DI_W];
  assign coord_f = s_tdata[COORD_LSB +: COORD_W];
  assign op_f    = s_tuser;

  assign s_tready = adv && !rst;

  // point coordinates past num_dims and opcode 3 are dropped at the entry
  assign pt_ok = (op_f == OP_POINT) && ({1'b0, di_f} < nd_eff);

  assign tok_c[0].valid = s_tvalid && !rst &&
                          ((op_f == OP_LOAD) || (op_f == OP_CLEAR) || pt_ok);
  assign tok_c[0].op    = op_f;
  assign tok_c[0].ci    = ci_f;
  assign tok_c[0].di    = di_f;
  assign tok_c[0].last  = ({1'b0, di_f} == (nd_eff - ND_W'(1)));
  assign best_c[0]      = '0;

  generate
    if (COORD_BITS <= COORD_W) begin : g_coord_narrow
      assign coord_c[0] = coord_f[COORD_BITS-1:0];
    end else begin : g_coord_wide
      assign coord_c[0] = COORD_BITS'(coord_f);
    end
  endgenerate

  genvar g;
  generate
    for (g = 0; g < MAX_CENTERS; g++) begin : g_cell
      kcc_cell #(
        .IDX        (g),
        .MAX_DIMS   (MAX_DIMS),
        .COORD_BITS (COORD_BITS)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .adv       (adv),
        .nc_eff    (nc_eff),
        .tok_in    (tok_c[g]),
        .coord_in  (coord_c[g]),
        .best_in   (best_c[g]),
        .tok_out   (tok_c[g+1]),
        .coord_out (coord_c[g+1]),
        .best_out  (best_c[g+1])
      );
    end
  endgenerate

  kcc_total u_total (
    .clk             (clk),
    .rst             (rst),
    .tok_end         (tok_c[MAX_CENTERS]),
    .best_end        (best_c[MAX_CENTERS]),
    .out_ready       (m_tready),
    .adv             (adv),
    .out_valid       (m_tvalid),
    .point_cost      (point_cost),
    .run_total       (run_total),
    .total_saturated (total_saturated)
  );

  assign m_tdata = {(M_TDATA_W - M_USED_W)'(0), total_saturated, run_total, point_cost};

endmodule

[sv/kcc_checker.sv]
module kcc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [kcc_pkg::M_TDATA_W-1:0] m_tdata
);
  import kcc_pkg::*;

  // output channel holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  // input is only held off by a stalled result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input not ready without an output stall");

  // a saturated total sits at its maximum
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[DIST_W + TOTAL_W] |-> m_tdata[DIST_W +: TOTAL_W] == TOTAL_MAX)
    else $error("saturation flag without full total");

  // no result right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result after reset");

endmodule

bind kmeans_clustering_cost_top kcc_checker u_kcc_checker (.*);
